>>> rtl/core/rcfs_pkg.sv
// ----------------------------------------------------------------------------
// rcfs_pkg: shared types and constants of the RC failsafe conditioner
// Load control bundle, command codes, register indexes and the fixed
// decay, limit and saturation constants used by the lanes.
// ----------------------------------------------------------------------------
package rcfs_pkg;

   // Command codes carried by an input transaction
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // CSR indexes (byte address / 4)
   localparam logic [1:0] REG_UNIPOLAR_GAIN = 2'd0;
   localparam logic [1:0] REG_BIPOLAR_GAIN  = 2'd1;
   localparam logic [1:0] REG_SWITCH_HOLD   = 2'd2;

   // CSR reset values
   localparam logic [15:0] UNIPOLAR_GAIN_RST = 16'd16;
   localparam logic [15:0] BIPOLAR_GAIN_RST  = 16'd32;
   localparam logic [7:0]  SWITCH_HOLD_RST   = 8'd3;

   // Failsafe decay: sticks by 29/32, throttle by 126/128
   localparam int STICK_DECAY_MUL   = 29;
   localparam int STICK_DECAY_SHIFT = 5;
   localparam int THR_DECAY_MUL     = 126;
   localparam int THR_DECAY_SHIFT   = 7;

   // Decayed throttle above this keeps the held switch enabled
   localparam int THR_SWITCH_LIMIT = 200;

   // Q1.15 limits and throttle deadband (0.01)
   localparam int Q15_MAX      = 32767;
   localparam int Q15_MIN      = -32768;
   localparam int THR_DEADBAND = 328;

   // Per-transaction load strobe broadcast to every lane
   typedef struct packed {
      logic load;   // input transaction accepted this cycle
      logic tick;   // accepted transaction is a timeout tick
   } rcfs_load_type;

endpackage

>>> rtl/core/rc_failsafe_conditioner_core.sv
// ----------------------------------------------------------------------------
// rc_failsafe_conditioner_core: RC receiver channel conditioner
// Stores fresh frames or decays held channels on timeout ticks, then
// scales every channel to Q1.15 and debounces the control switch.
//
//   Channel  Prefix  Direction  Handshake         Content
//   input    req_    in         valid / ready     command and raw channels
//   result   rsp_    out        valid / ready     Q1.15 channels and switch
//   config   csr_    in         APB, pready = 1   gains and switch hold count
//
// One transaction per cycle while the result is not stalled; the result
// passes the held-channel register, then the output register.
// Four channel lanes each hold one channel and one gain multiplier; the
// merge stage debounces the switch and owns the output register.
// A stalled result holds one transaction in the held stage; the input
// stalls only when both that stage and the output register are full.
// Reset is synchronous: held channels, switch budget and CSRs take their
// reset values.
// ----------------------------------------------------------------------------
module rc_failsafe_conditioner_core #(
   parameter int CHANNEL_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic signed [CHANNEL_BITS-1:0] req_roll_raw,
   input  logic signed [CHANNEL_BITS-1:0] req_pitch_raw,
   input  logic [CHANNEL_BITS-1:0]        req_throttle_raw,
   input  logic signed [CHANNEL_BITS-1:0] req_yaw_raw,
   input  logic                           req_switch_raw,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [14:0]                    rsp_throttle_out,
   output logic signed [15:0]             rsp_roll_out,
   output logic signed [15:0]             rsp_pitch_out,
   output logic signed [15:0]             rsp_yaw_out,
   output logic                           rsp_switch_out,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [3:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   rcfs_pkg::rcfs_load_type load;

   logic [15:0]        unipolar_gain_ff;
   logic [15:0]        bipolar_gain_ff;
   logic [7:0]         switch_hold_ff;
   logic [1:0]         csr_index;
   logic               csr_write;
   logic               thr_decay_over;
   logic [14:0]        thr_value;
   logic signed [15:0] roll_value;
   logic signed [15:0] pitch_value;
   logic signed [15:0] yaw_value;

   // Input transaction strobe
   assign load.load = req_valid && req_ready;
   assign load.tick = (req_command == rcfs_pkg::CMD_TICK);

   // CSR write and read
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         unipolar_gain_ff <= rcfs_pkg::UNIPOLAR_GAIN_RST;
         bipolar_gain_ff  <= rcfs_pkg::BIPOLAR_GAIN_RST;
         switch_hold_ff   <= rcfs_pkg::SWITCH_HOLD_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            rcfs_pkg::REG_UNIPOLAR_GAIN: unipolar_gain_ff <= csr_pwdata[15:0];
            rcfs_pkg::REG_BIPOLAR_GAIN:  bipolar_gain_ff  <= csr_pwdata[15:0];
            rcfs_pkg::REG_SWITCH_HOLD:   switch_hold_ff   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rcfs_pkg::REG_UNIPOLAR_GAIN: csr_prdata = {16'd0, unipolar_gain_ff};
         rcfs_pkg::REG_BIPOLAR_GAIN:  csr_prdata = {16'd0, bipolar_gain_ff};
         rcfs_pkg::REG_SWITCH_HOLD:   csr_prdata = {24'd0, switch_hold_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // Channel lanes
   rcfs_throttle_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_thr_lane (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .raw        (req_throttle_raw),
      .gain       (unipolar_gain_ff),
      .decay_over (thr_decay_over),
      .value      (thr_value)
   );

   rcfs_stick_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_roll_lane (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .raw    (req_roll_raw),
      .gain   (bipolar_gain_ff),
      .invert (1'b0),
      .value  (roll_value)
   );

   rcfs_stick_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_pitch_lane (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .raw    (req_pitch_raw),
      .gain   (bipolar_gain_ff),
      .invert (1'b1),
      .value  (pitch_value)
   );

   rcfs_stick_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_yaw_lane (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .raw    (req_yaw_raw),
      .gain   (bipolar_gain_ff),
      .invert (1'b0),
      .value  (yaw_value)
   );

   // Merge stage: switch debounce, output register, handshake
   rcfs_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .switch_raw       (req_switch_raw),
      .thr_decay_over   (thr_decay_over),
      .hold_count       (switch_hold_ff),
      .thr_value        (thr_value),
      .roll_value       (roll_value),
      .pitch_value      (pitch_value),
      .yaw_value        (yaw_value),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_throttle_out (rsp_throttle_out),
      .rsp_roll_out     (rsp_roll_out),
      .rsp_pitch_out    (rsp_pitch_out),
      .rsp_yaw_out      (rsp_yaw_out),
      .rsp_switch_out   (rsp_switch_out)
   );

endmodule

>>> rtl/core/rcfs_stick_lane.sv
// ----------------------------------------------------------------------------
// rcfs_stick_lane: one signed stick channel (roll, pitch or yaw)
// Holds the channel, decays it by 29/32 on a tick, and scales the held
// value by the bipolar gain to a saturated Q1.15 result.
// ----------------------------------------------------------------------------
module rcfs_stick_lane #(
   parameter int CHANNEL_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rcfs_pkg::rcfs_load_type        load,
   input  logic signed [CHANNEL_BITS-1:0] raw,
   input  logic [15:0]                    gain,
   input  logic                           invert,
   output logic signed [15:0]             value
);

   localparam int DW = CHANNEL_BITS + 6;    // decay product width
   localparam int PW = CHANNEL_BITS + 18;   // scale product width (with negate)

   localparam logic signed [DW-1:0] DECAY_MUL = DW'(rcfs_pkg::STICK_DECAY_MUL);
   localparam logic signed [PW-1:0] SAT_HI    = PW'(rcfs_pkg::Q15_MAX);
   localparam logic signed [PW-1:0] SAT_LO    = PW'(rcfs_pkg::Q15_MIN);

   logic signed [CHANNEL_BITS-1:0] held_ff;
   logic signed [CHANNEL_BITS-1:0] held_in;
   logic signed [DW-1:0]           decay_prod;
   logic signed [DW-1:0]           decay_shift;
   logic signed [CHANNEL_BITS-1:0] decayed;
   logic signed [PW-1:0]           scale_prod;
   logic signed [PW-1:0]           scale_sgn;
   logic signed [PW-1:0]           scale_half;

   // Decay: floor(held * 29 / 32), arithmetic shift rounds down
   assign decay_prod  = $signed({{6{held_ff[CHANNEL_BITS-1]}}, held_ff}) * DECAY_MUL;
   assign decay_shift = decay_prod >>> rcfs_pkg::STICK_DECAY_SHIFT;
   assign decayed     = decay_shift[CHANNEL_BITS-1:0];

   // Held channel register
   always_comb begin
      held_in = held_ff;
      if (load.load) begin
         held_in = load.tick ? decayed : raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // Scale by gain, optional sign reversal, floor halve
   assign scale_prod = $signed({{18{held_ff[CHANNEL_BITS-1]}}, held_ff})
                     * $signed({{(CHANNEL_BITS + 2){1'b0}}, gain});
   assign scale_sgn  = invert ? -scale_prod : scale_prod;
   assign scale_half = scale_sgn >>> 1;

   // Saturate to Q1.15
   always_comb begin
      priority if (scale_half > SAT_HI) begin
         value = SAT_HI[15:0];
      end else if (scale_half < SAT_LO) begin
         value = SAT_LO[15:0];
      end else begin
         value = scale_half[15:0];
      end
   end

endmodule

>>> rtl/core/rcfs_throttle_lane.sv
// ----------------------------------------------------------------------------
// rcfs_throttle_lane: unsigned throttle channel
// Holds throttle, decays it by 126/128 on a tick, flags a decayed value
// above the switch limit, and scales to Q1.15 with saturation and deadband.
// ----------------------------------------------------------------------------
module rcfs_throttle_lane #(
   parameter int CHANNEL_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rcfs_pkg::rcfs_load_type load,
   input  logic [CHANNEL_BITS-1:0] raw,
   input  logic [15:0]             gain,
   output logic                    decay_over,
   output logic [14:0]             value
);

   localparam int DW = CHANNEL_BITS + 7;
   localparam int PW = CHANNEL_BITS + 16;

   localparam logic [DW-1:0] DECAY_MUL = DW'(rcfs_pkg::THR_DECAY_MUL);
   localparam logic [CHANNEL_BITS-1:0] SW_LIMIT =
      CHANNEL_BITS'(rcfs_pkg::THR_SWITCH_LIMIT);
   localparam logic [PW-1:0] SAT_HI   = PW'(rcfs_pkg::Q15_MAX);
   localparam logic [14:0]   DEADBAND = 15'(rcfs_pkg::THR_DEADBAND);

   logic [CHANNEL_BITS-1:0] held_ff;
   logic [CHANNEL_BITS-1:0] held_in;
   logic [DW-1:0]           decay_prod;
   logic [DW-1:0]           decay_shift;
   logic [CHANNEL_BITS-1:0] decayed;
   logic [PW-1:0]           scale_prod;
   logic [PW-1:0]           scale_half;
   logic [14:0]             sat_val;

   // Decay: floor(held * 126 / 128)
   assign decay_prod  = {7'd0, held_ff} * DECAY_MUL;
   assign decay_shift = decay_prod >> rcfs_pkg::THR_DECAY_SHIFT;
   assign decayed     = decay_shift[CHANNEL_BITS-1:0];
   assign decay_over  = (decayed > SW_LIMIT);

   // Held throttle register
   always_comb begin
      held_in = held_ff;
      if (load.load) begin
         held_in = load.tick ? decayed : raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // Scale, halve, saturate, then deadband
   assign scale_prod = {16'd0, held_ff} * {{CHANNEL_BITS{1'b0}}, gain};
   assign scale_half = scale_prod >> 1;
   assign sat_val    = (scale_half > SAT_HI) ? SAT_HI[14:0] : scale_half[14:0];
   assign value      = (sat_val < DEADBAND) ? 15'd0 : sat_val;

endmodule

>>> rtl/core/rcfs_merge.sv
// ----------------------------------------------------------------------------
// rcfs_merge: merging stage of the conditioner
// Tracks the held switch, debounces it, gathers the lane results into the
// output register and runs the transaction handshake of both channels.
// ----------------------------------------------------------------------------
module rcfs_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  rcfs_pkg::rcfs_load_type load,
   input  logic                    switch_raw,
   input  logic                    thr_decay_over,
   input  logic [7:0]              hold_count,
   input  logic [14:0]             thr_value,
   input  logic signed [15:0]      roll_value,
   input  logic signed [15:0]      pitch_value,
   input  logic signed [15:0]      yaw_value,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [14:0]             rsp_throttle_out,
   output logic signed [15:0]      rsp_roll_out,
   output logic signed [15:0]      rsp_pitch_out,
   output logic signed [15:0]      rsp_yaw_out,
   output logic                    rsp_switch_out
);

   logic              stage_valid_ff;
   logic              stage_valid_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              held_switch_ff;
   logic              held_switch_in;
   logic [7:0]        budget_ff;
   logic [7:0]        budget_in;
   logic              sw_next;
   logic              advance;
   logic [14:0]       thr_ff;
   logic signed [15:0] roll_ff;
   logic signed [15:0] pitch_ff;
   logic signed [15:0] yaw_ff;
   logic              sw_ff;

   // Handshake: the held stage moves out when the output register is free
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (load.load) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Held switch: raw on a frame, throttle threshold on a tick
   always_comb begin
      held_switch_in = held_switch_ff;
      if (load.load) begin
         held_switch_in = load.tick ? thr_decay_over : switch_raw;
      end
   end

   // Debounce: reload on high, spend budget on low
   always_comb begin
      budget_in = budget_ff;
      sw_next   = 1'b1;
      priority if (held_switch_ff) begin
         budget_in = hold_count;
      end else if (budget_ff != 8'd0) begin
         budget_in = budget_ff - 8'd1;
      end else begin
         sw_next = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         held_switch_ff <= 1'b0;
         budget_ff      <= 8'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         held_switch_ff <= held_switch_in;
         if (advance) begin
            budget_ff <= budget_in;
         end
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (advance) begin
         thr_ff   <= thr_value;
         roll_ff  <= roll_value;
         pitch_ff <= pitch_value;
         yaw_ff   <= yaw_value;
         sw_ff    <= sw_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_throttle_out = thr_ff;
   assign rsp_roll_out     = roll_ff;
   assign rsp_pitch_out    = pitch_ff;
   assign rsp_yaw_out      = yaw_ff;
   assign rsp_switch_out   = sw_ff;

`ifndef SYNTHESIS
   // A new load never overwrites a held stage that cannot move out
   assert property (@(posedge clock) disable iff (reset)
      (load.load && stage_valid_ff) |-> advance)
      else $error("load into a stalled stage");

   // An advanced transaction is presented on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced transaction not presented");

   // A dropped switch output means the budget is spent
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !sw_ff) |-> (budget_ff == 8'd0))
      else $error("switch dropped with budget left");

   // Full stage behind a stalled output blocks the input
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input ready while pipeline stalled");
`endif

endmodule
